// ===== hw/rtl/lcdpc_pkg.sv =====
package lcdpc_pkg;

  // Panel and display RAM geometry.
  localparam int MAX_WIDTH     = 128;
  localparam int MAX_BANKS     = 16;
  localparam int DDRAM_COLUMNS = 132;
  localparam int STORE_DEPTH   = MAX_WIDTH * MAX_BANKS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  localparam logic [7:0] WIDTH_MAX_C  = 8'(MAX_WIDTH);
  localparam logic [4:0] BANKS_MAX_C  = 5'(MAX_BANKS);
  localparam logic [7:0] DDRAM_COLS_C = 8'(DDRAM_COLUMNS);

  // Action codes of an input word.
  localparam logic [1:0] ACT_CMD  = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Display mode codes.
  localparam logic [1:0] MODE_BLANK   = 2'd0;
  localparam logic [1:0] MODE_ALL_ON  = 2'd1;
  localparam logic [1:0] MODE_NORMAL  = 2'd2;
  localparam logic [1:0] MODE_INVERSE = 2'd3;

  // Bank/column controller command codes.
  localparam logic [7:0] CMD_FUNC_MASK = 8'hF8;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h20;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h08;
  localparam logic [7:0] CMD_BANK_MASK = 8'hC0;
  localparam logic [7:0] CMD_BANK_SET  = 8'h40;

  // Page controller command codes.
  localparam logic [7:0] CMD_PAGE_FIRST  = 8'hB0;
  localparam logic [7:0] CMD_PAGE_LAST   = 8'hBF;
  localparam logic [7:0] CMD_COL_LO_LAST = 8'h0F;
  localparam logic [7:0] CMD_COL_HI_LAST = 8'h1F;
  localparam logic [7:0] CMD_DISP_OFF    = 8'hAE;
  localparam logic [7:0] CMD_DISP_ON     = 8'hAF;
  localparam logic [7:0] CMD_ALL_OFF     = 8'hA4;
  localparam logic [7:0] CMD_ALL_ON      = 8'hA5;
  localparam logic [7:0] CMD_REV_OFF     = 8'hA6;
  localparam logic [7:0] CMD_REV_ON      = 8'hA7;
  localparam logic [7:0] CMD_SEG_NORMAL  = 8'hA0;
  localparam logic [7:0] CMD_SEG_REVERSE = 8'hA1;
  localparam logic [7:0] CMD_CONTRAST    = 8'h81;
  localparam logic [7:0] CMD_INDICATOR   = 8'hAD;

  // Configuration register indexes.
  localparam logic [2:0] REG_KIND    = 3'd0;
  localparam logic [2:0] REG_WIDTH   = 3'd1;
  localparam logic [2:0] REG_BANKS   = 3'd2;
  localparam logic [2:0] REG_OFFSET  = 3'd3;
  localparam logic [2:0] REG_MIRROR  = 3'd4;
  localparam int         PADDR_W     = 5;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [6:0] pixel_x;
    logic [6:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic       pixel_on;
    logic [1:0] display_mode;
  } out_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] width;
    logic [4:0] banks;
    logic [7:0] offset;
    logic       mirrored;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic       in_range;
    logic [2:0] bit_sel;
    logic [1:0] mode;
  } rd_info_t;

endpackage

// ===== hw/rtl/dual_mode_lcd_page_controller_unit.sv =====
// Channel   Direction  Handshake             Word
// in_       input      in_valid / in_ready   in_word_t (action, byte, pixel x/y)
// out_      output     out_valid / out_ready out_word_t (pixel_on, display_mode)
// cfg_      input      APB write/read        32-bit registers at 4*index
//
// One word is accepted per cycle while in_ready is high; commands and data bytes finish at
// the accepting edge. For a pixel read, the frame store read and the read stage are
// registered at the accepting edge; the output register loads from the read stage once free.
// After reset the frame store is cleared, all 2048 entries, one entry per cycle, and
// in_ready stays low; configuration writes are taken throughout.
// A stalled output holds one result in the read stage and one in the output register.
module dual_mode_lcd_page_controller_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lcdpc_pkg::in_word_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lcdpc_pkg::out_word_t              out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lcdpc_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import lcdpc_pkg::*;

  cfg_t     cfg_r;
  logic     cfg_wr;
  logic     accept;
  logic     clr_done;
  logic     s1_free;
  logic     rd_fire;
  mem_req_t mem_req;
  rd_info_t rd_info;
  logic [7:0] rdata;

  // Register file behind the APB port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind     <= 1'b0;
      cfg_r.width    <= 8'd84;
      cfg_r.banks    <= 5'd6;
      cfg_r.offset   <= 8'd0;
      cfg_r.mirrored <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_KIND:   cfg_r.kind     <= cfg_pwdata[0];
        REG_WIDTH:  cfg_r.width    <= cfg_pwdata[7:0];
        REG_BANKS:  cfg_r.banks    <= cfg_pwdata[4:0];
        REG_OFFSET: cfg_r.offset   <= cfg_pwdata[7:0];
        REG_MIRROR: cfg_r.mirrored <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_KIND:   cfg_prdata = {31'd0, cfg_r.kind};
      REG_WIDTH:  cfg_prdata = {24'd0, cfg_r.width};
      REG_BANKS:  cfg_prdata = {27'd0, cfg_r.banks};
      REG_OFFSET: cfg_prdata = {24'd0, cfg_r.offset};
      REG_MIRROR: cfg_prdata = {31'd0, cfg_r.mirrored};
      default:    cfg_prdata = '0;
    endcase
  end

  // Input handshake.
  assign in_ready = clr_done && s1_free;
  assign accept   = in_valid && in_ready;

  lcdpc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg_r),
    .mem_req (mem_req),
    .rd_info (rd_info),
    .rd_fire (rd_fire)
  );

  lcdpc_fstore u_fstore (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rdata    (rdata),
    .clr_done (clr_done)
  );

  lcdpc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_fire   (rd_fire),
    .rd_info   (rd_info),
    .rdata     (rdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .s1_free   (s1_free)
  );

endmodule

// ===== hw/rtl/lcdpc_fstore.sv =====
module lcdpc_fstore (
  input  logic               clk,
  input  logic               rst_n,
  input  lcdpc_pkg::mem_req_t req,
  output logic [7:0]         rdata,
  output logic               clr_done
);
  import lcdpc_pkg::*;

  logic [7:0]      store_mem [STORE_DEPTH];
  logic [ADDR_W:0] clr_cnt_r;
  logic [7:0]      rdata_r;

  assign clr_done = clr_cnt_r[ADDR_W];
  assign rdata    = rdata_r;

  // Clearing pass: one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (!clr_done) begin
      store_mem[clr_cnt_r[ADDR_W-1:0]] <= '0;
    end else if (req.we) begin
      store_mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= store_mem[req.addr];
    end
  end

endmodule

// ===== hw/rtl/lcdpc_ctrl.sv =====
module lcdpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  lcdpc_pkg::in_word_t in_data,
  input  lcdpc_pkg::cfg_t     cfg,
  output lcdpc_pkg::mem_req_t mem_req,
  output lcdpc_pkg::rd_info_t rd_info,
  output logic                rd_fire
);
  import lcdpc_pkg::*;

  logic [7:0] col_r, col_nxt;
  logic [3:0] bank_r, bank_nxt;
  logic       vert_r, vert_nxt;
  logic       ext_r, ext_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       disp_en_r, disp_en_nxt;
  logic       all_on_r, all_on_nxt;
  logic       rev_r, rev_nxt;
  logic       seg_rev_r, seg_rev_nxt;
  logic       arg_pend_r, arg_pend_nxt;

  logic [7:0]  eff_w;
  logic [4:0]  eff_n;
  logic [7:0]  b;
  logic [3:0]  bank_clamped;
  logic [6:0]  cmd_col;
  logic [8:0]  x_inc;
  logic        x_wrap;
  logic [4:0]  y_inc;
  logic        y_wrap;
  logic        bank_ok;
  logic        k0_ok;
  logic [6:0]  k0_col;
  logic [7:0]  k1_diff;
  logic        k1_ok;
  logic [6:0]  k1_col;
  logic        k1_mir;
  logic        en_t, all_t, rev_t;
  logic        is_read;
  logic [3:0]  bank_sel;
  logic [6:0]  col_sel;
  logic [11:0] prod;
  logic [11:0] addr_sum;

  // Effective geometry and shared helpers.
  always_comb begin
    b       = in_data.byte_value;
    eff_w   = (cfg.width == 8'd0) ? 8'd1 :
              ((cfg.width > WIDTH_MAX_C) ? WIDTH_MAX_C : cfg.width);
    eff_n   = (cfg.banks == 5'd0) ? 5'd1 :
              ((cfg.banks > BANKS_MAX_C) ? BANKS_MAX_C : cfg.banks);
    bank_clamped = ({1'b0, b[3:0]} >= eff_n) ? 4'(eff_n - 5'd1) : b[3:0];
    cmd_col = ({1'b0, b[6:0]} >= eff_w) ? 7'(eff_w - 8'd1) : b[6:0];
    x_inc   = {1'b0, col_r} + 9'd1;
    x_wrap  = x_inc >= {1'b0, eff_w};
    y_inc   = {1'b0, bank_r} + 5'd1;
    y_wrap  = y_inc >= eff_n;
    bank_ok = {1'b0, bank_r} < eff_n;
    // Bank/column controller store target.
    k0_ok   = (col_r < eff_w) && bank_ok;
    k0_col  = cfg.mirrored ? 7'(eff_w - 8'd1 - col_r) : col_r[6:0];
    // Page controller store target, windowed by the column offset.
    k1_diff = col_r - cfg.offset;
    k1_ok   = (col_r >= cfg.offset) && (k1_diff < eff_w) && bank_ok;
    k1_mir  = cfg.mirrored ^ seg_rev_r;
    k1_col  = k1_mir ? 7'(eff_w - 8'd1 - k1_diff) : k1_diff[6:0];
  end

  // Next state for commands and data bytes.
  always_comb begin
    col_nxt      = col_r;
    bank_nxt     = bank_r;
    vert_nxt     = vert_r;
    ext_nxt      = ext_r;
    mode_nxt     = mode_r;
    disp_en_nxt  = disp_en_r;
    all_on_nxt   = all_on_r;
    rev_nxt      = rev_r;
    seg_rev_nxt  = seg_rev_r;
    arg_pend_nxt = arg_pend_r;
    en_t         = disp_en_r;
    all_t        = all_on_r;
    rev_t        = rev_r;
    if (accept) begin
      case (in_data.action)
        ACT_CMD: begin
          if (!cfg.kind) begin
            if ((b & CMD_FUNC_MASK) == CMD_FUNC_SET) begin
              ext_nxt  = b[0];
              vert_nxt = b[1];
            end else if (ext_r) begin
              // Extended instructions leave the picture alone.
            end else if ((b & CMD_FUNC_MASK) == CMD_DISP_CTRL) begin
              mode_nxt = {b[2], b[0]};
            end else if ((b & CMD_BANK_MASK) == CMD_BANK_SET) begin
              bank_nxt = bank_clamped;
            end else if (b[7]) begin
              col_nxt = {1'b0, cmd_col};
            end
          end else if (arg_pend_r) begin
            // Argument byte of a two-byte command is swallowed.
            arg_pend_nxt = 1'b0;
          end else begin
            if (b inside {[CMD_PAGE_FIRST:CMD_PAGE_LAST]}) begin
              bank_nxt = bank_clamped;
            end else if (b <= CMD_COL_LO_LAST) begin
              col_nxt = {col_r[7:4], b[3:0]};
            end else if (b <= CMD_COL_HI_LAST) begin
              col_nxt = {b[3:0], col_r[3:0]};
            end else if (b inside {CMD_DISP_OFF, CMD_DISP_ON}) begin
              en_t = b[0];
            end else if (b inside {CMD_ALL_OFF, CMD_ALL_ON}) begin
              all_t = b[0];
            end else if (b inside {CMD_REV_OFF, CMD_REV_ON}) begin
              rev_t = b[0];
            end else if (b inside {CMD_SEG_NORMAL, CMD_SEG_REVERSE}) begin
              seg_rev_nxt = b[0];
            end else if (b inside {CMD_CONTRAST, CMD_INDICATOR}) begin
              arg_pend_nxt = 1'b1;
            end
            disp_en_nxt = en_t;
            all_on_nxt  = all_t;
            rev_nxt     = rev_t;
            mode_nxt    = !en_t ? MODE_BLANK :
                          (all_t ? MODE_ALL_ON : (rev_t ? MODE_INVERSE : MODE_NORMAL));
          end
        end
        ACT_DATA: begin
          if (!cfg.kind) begin
            if (vert_r) begin
              bank_nxt = y_wrap ? 4'd0 : y_inc[3:0];
              col_nxt  = y_wrap ? (x_wrap ? 8'd0 : x_inc[7:0]) : col_r;
            end else begin
              col_nxt  = x_wrap ? 8'd0 : x_inc[7:0];
              bank_nxt = x_wrap ? (y_wrap ? 4'd0 : y_inc[3:0]) : bank_r;
            end
          end else if (col_r < DDRAM_COLS_C) begin
            col_nxt = x_inc[7:0];
          end
        end
        default: begin
          // Pixel reads and the unused code leave the state alone.
        end
      endcase
    end
  end

  // Shared address path: bank times width plus column.
  always_comb begin
    is_read  = in_data.action == ACT_READ;
    bank_sel = is_read ? in_data.pixel_y[6:3] : bank_r;
    col_sel  = is_read ? in_data.pixel_x : (cfg.kind ? k1_col : k0_col);
    prod     = {8'd0, bank_sel} * {4'd0, eff_w};
    addr_sum = prod + {5'd0, col_sel};

    rd_fire       = accept && is_read;
    mem_req.re    = rd_fire;
    mem_req.we    = accept && (in_data.action == ACT_DATA) && (cfg.kind ? k1_ok : k0_ok);
    mem_req.addr  = addr_sum[ADDR_W-1:0];
    mem_req.wdata = b;

    rd_info.in_range = ({1'b0, in_data.pixel_x} < eff_w) &&
                       ({1'b0, in_data.pixel_y} < {eff_n[4:0], 3'b000});
    rd_info.bit_sel  = in_data.pixel_y[2:0];
    rd_info.mode     = mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      bank_r     <= '0;
      vert_r     <= 1'b0;
      ext_r      <= 1'b0;
      mode_r     <= MODE_BLANK;
      disp_en_r  <= 1'b0;
      all_on_r   <= 1'b0;
      rev_r      <= 1'b0;
      seg_rev_r  <= 1'b0;
      arg_pend_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      bank_r     <= bank_nxt;
      vert_r     <= vert_nxt;
      ext_r      <= ext_nxt;
      mode_r     <= mode_nxt;
      disp_en_r  <= disp_en_nxt;
      all_on_r   <= all_on_nxt;
      rev_r      <= rev_nxt;
      seg_rev_r  <= seg_rev_nxt;
      arg_pend_r <= arg_pend_nxt;
    end
  end

endmodule

// ===== hw/rtl/lcdpc_out.sv =====
module lcdpc_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_fire,
  input  lcdpc_pkg::rd_info_t  rd_info,
  input  logic [7:0]           rdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output lcdpc_pkg::out_word_t out_data,
  output logic                 s1_free
);
  import lcdpc_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  rd_info_t  s1_info_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;
  logic      s1_move;
  logic      raw;
  out_word_t res;

  // Read stage waits on the memory data, then moves into the output register.
  always_comb begin
    s1_move       = s1_valid_r && (!out_valid_r || out_ready);
    s1_free       = !s1_valid_r || s1_move;
    s1_valid_nxt  = rd_fire || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && !out_ready);
  end

  // Display mode transform of the stored bit.
  always_comb begin
    raw = rdata[s1_info_r.bit_sel];
    res.display_mode = s1_info_r.mode;
    case (s1_info_r.mode)
      MODE_BLANK:   res.pixel_on = 1'b0;
      MODE_ALL_ON:  res.pixel_on = 1'b1;
      MODE_INVERSE: res.pixel_on = ~raw;
      default:      res.pixel_on = raw;
    endcase
    res.pixel_on = res.pixel_on && s1_info_r.in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      s1_info_r <= rd_info;
    end
    if (s1_move) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
